// ===== sv/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial frame parser package
// Shared types and constants for the frame parser and forwarder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

    // Opcodes of an input word.
    localparam logic [1:0] OP_RX      = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_PULL    = 2'd3;

    // Buffer occupancy codes.
    localparam logic [1:0] OCC_FREE  = 2'd0;
    localparam logic [1:0] OCC_LOCAL = 2'd1;
    localparam logic [1:0] OCC_FWD   = 2'd2;

    // Frame bytes.
    localparam logic [7:0] BYTE_SYNC0   = 8'hFE;
    localparam logic [7:0] BYTE_SYNC1   = 8'hEF;
    localparam logic [7:0] SUM_SEED     = 8'hED;
    localparam logic [7:0] DEV_LOCAL    = 8'h50;
    localparam logic [7:0] DEV_OTHER    = 8'h60;
    localparam logic [7:0] ADDR_BCAST   = 8'hFF;
    localparam logic [7:0] BYTE_END     = 8'h16;
    localparam logic [7:0] MIN_LENGTH   = 8'd3;
    localparam logic [7:0] RESET_ADDR   = 8'd1;

    // Parser states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SYNC,
        ST_DEV,
        ST_ADDR,
        ST_CMD,
        ST_LENL,
        ST_LENH,
        ST_PAY,
        ST_SUM,
        ST_END
    } t_pstate;

    // Result word before the payload memory data is merged in.
    typedef struct packed {
        logic       frame_ready;
        logic       ready_buffer;
        logic       read_from_ram;
        logic [7:0] frame_device;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
        logic       forward_valid;
        logic       forward_from_ram;
        logic [7:0] forward_byte;
        logic       forward_last;
        logic [7:0] forward_total;
        logic [3:0] buffer_status;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/sfp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/sfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frame parser control
// Parser state, buffer occupancy, headers and forward replay; drives the
// payload memory ports and forms the result word of each accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_ctrl #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_accept,
    input  wire [1:0]                        i_opcode,
    input  wire [7:0]                        i_rx_byte,
    input  wire                              i_buffer_select,
    input  wire [7:0]                        i_read_index,
    input  wire                              i_cfg_we,
    input  wire [7:0]                        i_cfg_data,
    output logic                             o_ram_we,
    output logic [$clog2(BUFFER_DEPTH):0]    o_ram_waddr,
    output logic [7:0]                       o_ram_wdata,
    output logic                             o_ram_re,
    output logic [$clog2(BUFFER_DEPTH):0]    o_ram_raddr,
    output sfp_pkg::t_result                 o_result
);
    import sfp_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

    t_pstate    r_state, n_state;
    logic [7:0] r_sum, n_sum;
    logic       r_active, n_active;
    logic [7:0] r_lenlo, n_lenlo;
    logic [8:0] r_cnt, n_cnt;
    logic [1:0] r_occ [2];
    logic [1:0] n_occ [2];
    logic [7:0] r_dev [2];
    logic [7:0] r_adr [2];
    logic [7:0] r_cmd [2];
    logic [7:0] r_len [2];
    logic [7:0] r_chk [2];
    logic [7:0] n_dev [2];
    logic [7:0] n_adr [2];
    logic [7:0] n_cmd [2];
    logic [7:0] n_len [2];
    logic [7:0] n_chk [2];
    logic [8:0] r_fpos, n_fpos;
    logic [7:0] r_fcnt, n_fcnt;
    logic       r_fsrc, n_fsrc;
    logic [7:0] r_my_addr;

    logic       rx;
    logic       b;
    logic [8:0] cnt_inc;
    logic [7:0] sum_add;

    assign rx      = i_accept && (i_opcode == OP_RX);
    assign b       = r_active;
    assign cnt_inc = r_cnt + 9'd1;
    assign sum_add = r_sum + i_rx_byte;

    // Next parser state.
    always_comb begin
        n_state = r_state;
        if (rx) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_rx_byte == BYTE_SYNC0 &&
                        (r_occ[0] == OCC_FREE || r_occ[1] == OCC_FREE)) begin
                        n_state = ST_SYNC;
                    end
                end
                ST_SYNC: n_state = (i_rx_byte == BYTE_SYNC1) ? ST_DEV : ST_IDLE;
                ST_DEV: begin
                    n_state = (i_rx_byte == DEV_LOCAL || i_rx_byte == DEV_OTHER) ?
                              ST_ADDR : ST_IDLE;
                end
                ST_ADDR: n_state = ST_CMD;
                ST_CMD:  n_state = ST_LENL;
                ST_LENL: n_state = ST_LENH;
                ST_LENH: begin
                    if (i_rx_byte != 8'd0) begin
                        n_state = ST_IDLE;
                    end else if (r_lenlo < MIN_LENGTH) begin
                        n_state = ST_SUM;
                    end else begin
                        n_state = ST_PAY;
                    end
                end
                ST_PAY: begin
                    if (({1'b0, cnt_inc} + 10'd2) == {2'b00, r_len[b]}) begin
                        n_state = ST_SUM;
                    end else if (cnt_inc >= DEPTH9) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_SUM: n_state = (r_sum == i_rx_byte) ? ST_END : ST_IDLE;
                ST_END: n_state = ST_IDLE;
                default: n_state = ST_IDLE;
            endcase
        end
    end

    // Datapath updates, memory accesses and the result word.
    always_comb begin
        logic       src;
        logic       have_src;
        logic [7:0] plen;
        logic [9:0] pay_end;
        logic [8:0] poff;
        n_sum    = r_sum;
        n_active = r_active;
        n_lenlo  = r_lenlo;
        n_cnt    = r_cnt;
        n_occ    = r_occ;
        n_dev    = r_dev;
        n_adr    = r_adr;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_chk    = r_chk;
        n_fpos   = r_fpos;
        n_fcnt   = r_fcnt;
        n_fsrc   = r_fsrc;
        o_ram_we    = 1'b0;
        o_ram_waddr = {b, r_cnt[AW-1:0]};
        o_ram_wdata = i_rx_byte;
        o_ram_re    = 1'b0;
        o_ram_raddr = {i_buffer_select, i_read_index[AW-1:0]};
        o_result    = '0;
        src      = r_fsrc;
        have_src = 1'b1;
        plen     = 8'd0;
        pay_end  = 10'd0;
        poff     = r_fpos - 9'd7;

        if (i_accept) begin
            unique case (i_opcode)
                OP_RX: begin
                    unique case (r_state)
                        ST_IDLE: begin
                            if (i_rx_byte == BYTE_SYNC0) begin
                                if (r_occ[0] == OCC_FREE) begin
                                    n_active = 1'b0;
                                end else if (r_occ[1] == OCC_FREE) begin
                                    n_active = 1'b1;
                                end
                            end
                        end
                        ST_SYNC: begin
                            if (i_rx_byte == BYTE_SYNC1) begin
                                n_sum = SUM_SEED;
                            end
                        end
                        ST_DEV: begin
                            n_dev[b] = i_rx_byte;
                            if (i_rx_byte == DEV_LOCAL || i_rx_byte == DEV_OTHER) begin
                                n_sum = sum_add;
                            end
                        end
                        ST_ADDR: begin
                            n_adr[b] = i_rx_byte;
                            n_sum    = sum_add;
                        end
                        ST_CMD: begin
                            n_cmd[b] = i_rx_byte;
                            n_sum    = sum_add;
                        end
                        ST_LENL: begin
                            n_lenlo = i_rx_byte;
                            n_sum   = sum_add;
                        end
                        ST_LENH: begin
                            n_len[b] = r_lenlo;
                            n_sum    = sum_add;
                            n_cnt    = 9'd0;
                        end
                        ST_PAY: begin
                            o_ram_we = (r_cnt < DEPTH9);
                            n_sum    = sum_add;
                            n_cnt    = cnt_inc;
                        end
                        ST_SUM: begin
                            if (r_sum == i_rx_byte) begin
                                n_chk[b] = i_rx_byte;
                            end
                        end
                        ST_END: begin
                            if (i_rx_byte == BYTE_END) begin
                                if (r_dev[b] == DEV_LOCAL &&
                                    (r_adr[b] == r_my_addr || r_adr[b] == ADDR_BCAST)) begin
                                    n_occ[b] = OCC_LOCAL;
                                    o_result.frame_ready  = 1'b1;
                                    o_result.ready_buffer = b;
                                end else begin
                                    n_occ[b] = OCC_FWD;
                                    n_fcnt   = r_fcnt + 8'd1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_RELEASE: begin
                    if (r_occ[i_buffer_select] == OCC_FWD && r_fpos != 9'd0 &&
                        r_fsrc == i_buffer_select) begin
                        n_fpos = 9'd0;
                    end
                    n_occ[i_buffer_select] = OCC_FREE;
                end
                OP_READ: begin
                    if ({1'b0, i_read_index} < DEPTH9) begin
                        o_ram_re               = 1'b1;
                        o_result.read_from_ram = 1'b1;
                    end
                    o_result.frame_device  = r_dev[i_buffer_select];
                    o_result.frame_command = r_cmd[i_buffer_select];
                    o_result.frame_length  = r_len[i_buffer_select];
                end
                OP_PULL: begin
                    // A new frame starts from the lowest pending buffer.
                    if (r_fpos == 9'd0) begin
                        if (r_occ[0] == OCC_FWD) begin
                            src = 1'b0;
                        end else if (r_occ[1] == OCC_FWD) begin
                            src = 1'b1;
                        end else begin
                            have_src = 1'b0;
                        end
                        if (have_src) begin
                            n_fsrc = src;
                        end
                    end
                    plen    = (r_len[src] >= MIN_LENGTH) ? (r_len[src] - 8'd2) : 8'd0;
                    pay_end = 10'd7 + {2'b00, plen};
                    if (have_src) begin
                        o_result.forward_valid = 1'b1;
                        n_fpos = r_fpos + 9'd1;
                        priority if (r_fpos == 9'd0) begin
                            o_result.forward_byte = BYTE_SYNC0;
                        end else if (r_fpos == 9'd1) begin
                            o_result.forward_byte = BYTE_SYNC1;
                        end else if (r_fpos == 9'd2) begin
                            o_result.forward_byte = r_dev[src];
                        end else if (r_fpos == 9'd3) begin
                            o_result.forward_byte = r_adr[src];
                        end else if (r_fpos == 9'd4) begin
                            o_result.forward_byte = r_cmd[src];
                        end else if (r_fpos == 9'd5) begin
                            o_result.forward_byte = r_len[src];
                        end else if (r_fpos == 9'd6) begin
                            o_result.forward_byte = 8'd0;
                        end else if ({1'b0, r_fpos} < pay_end) begin
                            o_ram_re    = 1'b1;
                            o_ram_raddr = {src, poff[AW-1:0]};
                            o_result.forward_from_ram = 1'b1;
                        end else if ({1'b0, r_fpos} == pay_end) begin
                            o_result.forward_byte = r_chk[src];
                        end else begin
                            o_result.forward_byte = BYTE_END;
                            o_result.forward_last = 1'b1;
                            n_fpos     = 9'd0;
                            n_occ[src] = OCC_FREE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        o_result.forward_total = n_fcnt;
        o_result.buffer_status = {n_occ[1], n_occ[0]};
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sum     <= 8'd0;
            r_active  <= 1'b0;
            r_lenlo   <= 8'd0;
            r_cnt     <= 9'd0;
            r_occ[0]  <= OCC_FREE;
            r_occ[1]  <= OCC_FREE;
            r_fpos    <= 9'd0;
            r_fcnt    <= 8'd0;
            r_fsrc    <= 1'b0;
            r_my_addr <= RESET_ADDR;
        end else begin
            r_state  <= n_state;
            r_sum    <= n_sum;
            r_active <= n_active;
            r_lenlo  <= n_lenlo;
            r_cnt    <= n_cnt;
            r_occ    <= n_occ;
            r_fpos   <= n_fpos;
            r_fcnt   <= n_fcnt;
            r_fsrc   <= n_fsrc;
            if (i_cfg_we) begin
                r_my_addr <= i_cfg_data;
            end
        end
    end

    // Frame headers hold until rewritten.
    always_ff @(posedge i_clk) begin
        r_dev <= n_dev;
        r_adr <= n_adr;
        r_cmd <= n_cmd;
        r_len <= n_len;
        r_chk <= n_chk;
    end

endmodule

`default_nettype wire

// ===== sv/serial_frame_parser_forwarder_top.sv =====
// Output: a result word is offered in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output is not stalled; the payload memory read of a buffer read or
// a forward pull lands in the output stage, which holds it while stalled.
// Reset: synchronous, active low; parser idle, buffers free, counters zero,
// my_address 1. The payload memory and headers are not cleared.
// ----------------------------------------------------------------------------
// Serial frame parser and forwarder
// Top level: control, payload memory and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_parser_forwarder_top #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire [1:0]  i_opcode,
    input  wire [7:0]  i_rx_byte,
    input  wire        i_buffer_select,
    input  wire [7:0]  i_read_index,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [7:0]  i_cfg_data,
    output logic       o_valid,
    input  wire        i_ready,
    output logic       o_frame_ready,
    output logic       o_ready_buffer,
    output logic [7:0] o_read_data,
    output logic [7:0] o_frame_device,
    output logic [7:0] o_frame_command,
    output logic [7:0] o_frame_length,
    output logic       o_forward_valid,
    output logic [7:0] o_forward_byte,
    output logic       o_forward_last,
    output logic [7:0] o_forward_total,
    output logic [3:0] o_buffer_status
);
    import sfp_pkg::*;

    localparam int RAW = $clog2(BUFFER_DEPTH) + 1;

    logic         accept;
    logic         ram_we;
    logic         ram_re;
    logic [RAW-1:0] ram_waddr;
    logic [RAW-1:0] ram_raddr;
    logic [7:0]   ram_wdata;
    logic [7:0]   ram_rdata;
    t_result      result;
    t_result      r_res;
    logic         r_valid;

    assign o_ready     = !r_valid || i_ready;
    assign accept      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    sfp_ctrl #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_opcode        (i_opcode),
        .i_rx_byte       (i_rx_byte),
        .i_buffer_select (i_buffer_select),
        .i_read_index    (i_read_index),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_re        (ram_re),
        .o_ram_raddr     (ram_raddr),
        .o_result        (result)
    );

    sfp_ram #(.WIDTH(8), .DEPTH(2 * BUFFER_DEPTH)) u_payload (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= result;
        end
    end

    // Merge the memory data into the result word.
    assign o_valid         = r_valid;
    assign o_frame_ready   = r_res.frame_ready;
    assign o_ready_buffer  = r_res.ready_buffer;
    assign o_read_data     = r_res.read_from_ram ? ram_rdata : 8'd0;
    assign o_frame_device  = r_res.frame_device;
    assign o_frame_command = r_res.frame_command;
    assign o_frame_length  = r_res.frame_length;
    assign o_forward_valid = r_res.forward_valid;
    assign o_forward_byte  = r_res.forward_from_ram ? ram_rdata : r_res.forward_byte;
    assign o_forward_last  = r_res.forward_last;
    assign o_forward_total = r_res.forward_total;
    assign o_buffer_status = r_res.buffer_status;

endmodule

`default_nettype wire

// ===== sv/sfp_checker.sv =====
// ----------------------------------------------------------------------------
// Frame parser port checker
// Assertions on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_valid,
    input wire       i_ready,
    input wire       o_frame_ready,
    input wire       o_forward_valid,
    input wire [7:0] o_forward_byte,
    input wire       o_forward_last,
    input wire [3:0] o_buffer_status
);
    import sfp_pkg::*;

    // A result word stays offered until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped while stalled");

    // The last forward byte is a closing byte of a valid forward.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_forward_last |-> o_forward_valid && o_forward_byte == BYTE_END)
        else $error("forward last without closing byte");

    // A completed local frame and a forwarded byte never share a word.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_ready |-> !o_forward_valid)
        else $error("frame ready together with forward byte");

    // No buffer shows the unused occupancy code.
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_buffer_status[1:0] != 2'd3 && o_buffer_status[3:2] != 2'd3)
        else $error("illegal buffer status");

endmodule

bind serial_frame_parser_forwarder_top sfp_checker u_sfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_frame_ready   (o_frame_ready),
    .o_forward_valid (o_forward_valid),
    .o_forward_byte  (o_forward_byte),
    .o_forward_last  (o_forward_last),
    .o_buffer_status (o_buffer_status)
);

`default_nettype wire
